FILE: hdl/ccrf_pkg.sv
// Shared types, constants and helpers for the character command ring FIFO.
// No dependencies; imported by ccrf_front, ccrf_back and the top level.
package ccrf_pkg;

    // Ring geometry: SLOTS entries hold at most SLOTS-1 letters
    localparam int SLOTS = 16;
    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Character and count constants
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DRAIN   = 8'h31;
    localparam logic [7:0] CHAR_POP5    = 8'h32;
    localparam logic [7:0] CHAR_POP1    = 8'h33;
    localparam logic [6:0] CHAR_SPACE   = 7'h20;
    localparam int POP_FIVE_COUNT = 5;
    localparam int LEFT_W = $clog2(POP_FIVE_COUNT + 1);

    // Work codes passed from front to back
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_POP5  = 2'd2,
        OP_POP1  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] ch;
    } cmd_t;

    // Ring pointer advance modulo SLOTS
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(SLOTS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

FILE: hdl/ccrf_front.sv
// Front end: classifies received bytes and queues work for the back end.
// Depends on ccrf_pkg (cmd_t, op_t, character constants, queue depth).
module ccrf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_char,
    output logic                cmd_valid,
    output ccrf_pkg::cmd_t      cmd,
    input  logic                cmd_take
);
    import ccrf_pkg::*;

    cmd_t                  q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;

    logic   is_letter;
    logic   is_cmd;
    op_t    op_dec;
    logic   enq;
    logic   deq;

    // Classify the byte; anything not a letter or command is dropped
    always_comb
    begin
        is_letter = ((rx_char >= CHAR_UPPER_A) && (rx_char <= CHAR_UPPER_Z)) ||
                    ((rx_char >= CHAR_LOWER_A) && (rx_char <= CHAR_LOWER_Z));
        is_cmd    = 1'b1;
        op_dec    = OP_PUSH;
        if (is_letter)
            op_dec = OP_PUSH;
        else if (rx_char == CHAR_DRAIN)
            op_dec = OP_DRAIN;
        else if (rx_char == CHAR_POP5)
            op_dec = OP_POP5;
        else if (rx_char == CHAR_POP1)
            op_dec = OP_POP1;
        else
            is_cmd = 1'b0;
    end

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign enq       = push && !full && is_cmd;
    assign deq       = cmd_take && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg].op <= op_dec;
            q_mem[wr_ptr_reg].ch <= rx_char[6:0];
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({enq, deq})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hdl/ccrf_back.sv
// Back end: ring storage, pointers and the pop sequencer with output register.
// Depends on ccrf_pkg (cmd_t, op_t, ptr_adv, ring geometry).
module ccrf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ccrf_pkg::cmd_t      cmd,
    output logic                cmd_take,
    output logic                empty,
    input  logic                pop,
    output logic [6:0]          tx_char,
    output logic                last
);
    import ccrf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    logic [6:0]       ring_mem [SLOTS];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    state_t           state_reg;
    logic             drain_reg;
    logic [LEFT_W-1:0] left_reg;
    logic             out_valid_reg;
    logic [6:0]       tx_char_reg;
    logic             last_reg;

    logic             ring_empty;
    logic             out_free;
    logic             emit_now;
    logic [PTR_W-1:0] wp_adv;
    logic [PTR_W-1:0] rp_adv;
    logic             emit_last;
    logic             ring_we;

    assign ring_empty = (rp_reg == wp_reg);
    assign out_free   = !out_valid_reg || pop;
    assign emit_now   = (state_reg == ST_RUN) && out_free;
    assign wp_adv     = ptr_adv(wp_reg);
    assign rp_adv     = ptr_adv(rp_reg);
    assign cmd_take   = (state_reg == ST_IDLE) && cmd_valid;
    assign ring_we    = cmd_take && (cmd.op == OP_PUSH);
    assign emit_last  = drain_reg ? (rp_adv == wp_reg) : (left_reg == LEFT_W'(1));

    assign empty   = !out_valid_reg;
    assign tx_char = tx_char_reg;
    assign last    = last_reg;

    // Ring storage write
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= cmd.ch;
    end

    // Sequencer, pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            drain_reg     <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            tx_char_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // output slot: filled by an emit, freed by a pop transfer
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            OP_PUSH:
                            begin
                                wp_reg <= wp_adv;
                                // full ring: oldest letter is dropped
                                if (wp_adv == rp_reg)
                                    rp_reg <= rp_adv;
                            end
                            OP_DRAIN:
                            begin
                                drain_reg <= 1'b1;
                                if (!ring_empty)
                                    state_reg <= ST_RUN;
                            end
                            OP_POP5:
                            begin
                                drain_reg <= 1'b0;
                                left_reg  <= LEFT_W'(POP_FIVE_COUNT);
                                state_reg <= ST_RUN;
                            end
                            OP_POP1:
                            begin
                                drain_reg <= 1'b0;
                                left_reg  <= LEFT_W'(1);
                                state_reg <= ST_RUN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RUN:
                begin
                    // one result per cycle while the output slot is free
                    if (out_free)
                    begin
                        tx_char_reg   <= ring_empty ? CHAR_SPACE : ring_mem[rp_reg];
                        last_reg      <= emit_last;
                        if (!ring_empty)
                            rp_reg <= rp_adv;
                        left_reg <= left_reg - 1'b1;
                        if (emit_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/char_command_ring_fifo.sv
// Top level of the character command ring FIFO: front classifier plus back sequencer.
// Depends on ccrf_pkg, ccrf_front and ccrf_back.
//
//  channel  | ports                    | transfer when
//  ---------+--------------------------+-----------------------
//  input    | push, full, rx_char      | push && !full
//  result   | empty, pop, tx_char,last | pop && !empty
//
// A letter is written into the ring in the same cycle it leaves the command queue;
// a drain emits one result per cycle while the output slot is free (up to SLOTS-1),
// pop-five emits five results and pop-one one, paced by the single ring read port.
// Reset (rst_n low, asynchronous) empties the ring and the command queue.
// The four-entry command queue lets bytes arrive while results stall on pop.
module char_command_ring_fifo (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_char,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] tx_char,
    output logic       last
);
    import ccrf_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    ccrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_char   (rx_char),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    ccrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .tx_char   (tx_char),
        .last      (last)
    );

endmodule
